>>> src/dsfo_pkg.sv
// Shared types, constants and the operation sequence for the DSF oscillator.
// Used by dsfo_ctrl, dsfo_datapath and dsf_oscillator_top; no dependencies.
package dsfo_pkg;

    // Default build parameters
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF       = 32;
    localparam int SAMPLE_BITS_DEF      = 24;

    // Fixed field widths
    localparam int STEP_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BANDS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FALL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FALL2 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FALLP = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP   = 3'd5;

    // Formula select codes
    localparam logic [1:0] MODE_UP_BL = 2'd0;
    localparam logic [1:0] MODE_UP_UL = 2'd1;
    localparam logic [1:0] MODE_UD_BL = 2'd2;
    localparam logic [1:0] MODE_UD_UL = 2'd3;

    // Shared multiplier: signed operands, full product
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Sine polynomial coefficients, Q.28
    localparam logic [28:0] SIN_C1 = 29'd421657428;
    localparam logic [28:0] SIN_C3 = 29'd173399667;
    localparam logic [28:0] SIN_C5 = 29'd21392326;
    localparam logic [28:0] SIN_C7 = 29'd1256749;
    localparam logic [28:0] T_ONE  = 29'd268435456;

    // Datapath operations, one per sequencer step
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NB      = 5'd0;
    localparam logic [OP_W-1:0] OP_ANG_CB  = 5'd1;
    localparam logic [OP_W-1:0] OP_SIN_T2  = 5'd2;
    localparam logic [OP_W-1:0] OP_SIN_A5  = 5'd3;
    localparam logic [OP_W-1:0] OP_SIN_A3  = 5'd4;
    localparam logic [OP_W-1:0] OP_SIN_A1  = 5'd5;
    localparam logic [OP_W-1:0] OP_SIN_S   = 5'd6;
    localparam logic [OP_W-1:0] OP_DEN_A   = 5'd7;
    localparam logic [OP_W-1:0] OP_DEN_B   = 5'd8;
    localparam logic [OP_W-1:0] OP_ANG_T   = 5'd9;
    localparam logic [OP_W-1:0] OP_SAVE_S0 = 5'd10;
    localparam logic [OP_W-1:0] OP_NUM_A   = 5'd11;
    localparam logic [OP_W-1:0] OP_ANG_K1  = 5'd12;
    localparam logic [OP_W-1:0] OP_ANG_K0  = 5'd13;
    localparam logic [OP_W-1:0] OP_INN_A   = 5'd14;
    localparam logic [OP_W-1:0] OP_INN_P   = 5'd15;
    localparam logic [OP_W-1:0] OP_FIN     = 5'd16;

    // Sequence positions
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_UP_FIRST   = 6'd16;
    localparam logic [PC_W-1:0] PC_BAND_FIRST = 6'd22;
    localparam logic [PC_W-1:0] PC_FIN        = 6'd36;

    // Controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            issue;
        logic            wb;
        logic [OP_W-1:0] op;
        logic            div_init;
        logic            div_step;
        logic            out_load;
    } dsfo_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_full;
    } dsfo_stat_t;

    // Operation at each sequence position; a sine takes five steps
    function automatic logic [OP_W-1:0] prog_op(input logic [PC_W-1:0] pc);
        logic [OP_W-1:0] op;
        case (pc)
            6'd0:  op = OP_NB;
            6'd1:  op = OP_ANG_CB;
            6'd2, 6'd10, 6'd16, 6'd23, 6'd29: op = OP_SIN_T2;
            6'd3, 6'd11, 6'd17, 6'd24, 6'd30: op = OP_SIN_A5;
            6'd4, 6'd12, 6'd18, 6'd25, 6'd31: op = OP_SIN_A3;
            6'd5, 6'd13, 6'd19, 6'd26, 6'd32: op = OP_SIN_A1;
            6'd6, 6'd14, 6'd20, 6'd27, 6'd33: op = OP_SIN_S;
            6'd7:  op = OP_DEN_A;
            6'd8:  op = OP_DEN_B;
            6'd9:  op = OP_ANG_T;
            6'd15: op = OP_SAVE_S0;
            6'd21: op = OP_NUM_A;
            6'd22: op = OP_ANG_K1;
            6'd28: op = OP_ANG_K0;
            6'd34: op = OP_INN_A;
            6'd35: op = OP_INN_P;
            6'd36: op = OP_FIN;
            default: op = OP_FIN;
        endcase
        return op;
    endfunction

endpackage

>>> src/dsfo_ctrl.sv
// Sequencer for the DSF oscillator: steps the datapath through the formula,
// the divider and the output load. Depends on dsfo_pkg.
module dsfo_ctrl
    import dsfo_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] mode,
    input  dsfo_stat_t stat,
    output dsfo_cmd_t  cmd
);

    localparam int CNT_W = $clog2(SAMPLE_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next, pc_inc;
    logic             ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             skip_up, skip_band;

    // Skip the upper-only numerator terms in up-down modes, band terms in unlimited modes
    assign skip_up   = (mode == MODE_UD_BL) || (mode == MODE_UD_UL);
    assign skip_band = (mode == MODE_UP_UL) || (mode == MODE_UD_UL);

    always_comb begin
        pc_inc = pc_reg + 1'b1;
        if (pc_inc == PC_UP_FIRST && skip_up) begin
            pc_inc = PC_BAND_FIRST;
        end
        if (pc_inc == PC_BAND_FIRST && skip_band) begin
            pc_inc = PC_FIN;
        end
    end

    // Next state and command
    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.op       = prog_op(pc_reg);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    pc_next    = '0;
                    ph_next    = 1'b0;
                end
            end
            ST_RUN: begin
                if (!ph_reg) begin
                    cmd.issue = 1'b1;
                    ph_next   = 1'b1;
                end else begin
                    cmd.wb  = 1'b1;
                    ph_next = 1'b0;
                    if (pc_reg == PC_FIN) begin
                        state_next = ST_DINIT;
                    end else begin
                        pc_next = pc_inc;
                    end
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SAMPLE_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            ph_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
        end
    end

    // An accepted transaction starts the sequence
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RUN && pc_reg == '0))
        else $error("sequence did not start after accept");

    // Sequence never runs past the final step
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (pc_reg <= PC_FIN))
        else $error("sequence position out of range");

    // Divider ends after the step for its last quotient bit
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(SAMPLE_BITS - 1)) |=>
        (state_reg == ST_DONE))
        else $error("divider length wrong");

endmodule

>>> src/dsfo_datapath.sv
// Datapath of the DSF oscillator: phase accumulators, shared multiplier,
// polynomial sine, serial divider and output register. Depends on dsfo_pkg.
module dsfo_datapath
    import dsfo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dsfo_cmd_t              cmd,
    output dsfo_stat_t             stat,
    input  logic [1:0]             mode,
    input  logic [9:0]             band_count,
    input  logic [15:0]            falloff,
    input  logic [15:0]            falloff_squared,
    input  logic [15:0]            falloff_pow_n1,
    input  logic [23:0]            amplitude_recip,
    input  logic [STEP_W-1:0]      carrier_step,
    input  logic [STEP_W-1:0]      modulator_step,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic                   blocked
);

    localparam int PB = PHASE_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int LB = $clog2(SINE_TABLE_DEPTH);
    localparam logic [PB-1:0] QTR = PB'(1) << (PB - 2);
    localparam logic signed [MUL_W-1:0] Q28_ONE = 34'sd268435456;
    localparam logic [SB-1:0] MAG_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] MAG_NEG = {1'b1, {(SB-1){1'b0}}};

    logic [PB-1:0]              th_reg, be_reg, nb_reg, ang_reg, base;
    logic [28:0]                t2_reg, pacc_reg;
    logic signed [29:0]         sv_reg, s0_reg;
    logic signed [MUL_W-1:0]    den_reg, inn_reg, acc2_reg, num_reg;
    logic signed [40:0]         db_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [40:0]                rem_reg, ud_reg;
    logic                       lsb_reg, neg_reg, sat_reg, blk_reg;
    logic [SB-1:0]              quo_reg;
    logic                       m_tvalid_reg;
    logic [SB-1:0]              sample_reg;
    logic                       blocked_reg;

    logic [LB-1:0]              idx;
    logic [28:0]                t0, tt, sv_mag;
    logic signed [MUL_W-1:0]    op_a, op_b, a2q, p16;
    logic signed [PROD_W-1:0]   p_sh16, p_sh28;
    logic [MUL_W-1:0]           un;
    logic [40:0]                ud;
    logic [41:0]                sh;
    logic                       ge;
    logic [SB-1:0]              res;

    // Sine argument: quadrant and folded position, Q1.28
    assign idx    = ang_reg[PB-1 -: LB];
    assign t0     = 29'(idx[LB-3:0]) << (30 - LB);
    assign tt     = idx[LB-2] ? (T_ONE - t0) : t0;
    assign sv_mag = prod_reg[56:28];

    assign a2q    = signed'({6'd0, falloff_squared, 12'd0});
    assign p_sh16 = prod_reg >>> 16;
    assign p_sh28 = prod_reg >>> 28;
    assign p16    = signed'(p_sh16[MUL_W-1:0]);
    assign base   = (mode == MODE_UP_BL) ? th_reg : QTR;

    // Multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_NB:     begin op_a = MUL_W'(band_count); op_b = MUL_W'(be_reg); end
            OP_SIN_T2: begin op_a = MUL_W'(tt);       op_b = MUL_W'(tt);       end
            OP_SIN_A5: begin op_a = MUL_W'(t2_reg);   op_b = MUL_W'(SIN_C7);   end
            OP_SIN_A3: begin op_a = MUL_W'(t2_reg);   op_b = MUL_W'(pacc_reg); end
            OP_SIN_A1: begin op_a = MUL_W'(t2_reg);   op_b = MUL_W'(pacc_reg); end
            OP_SIN_S:  begin op_a = MUL_W'(tt);       op_b = MUL_W'(pacc_reg); end
            OP_DEN_A:  begin op_a = MUL_W'(sv_reg);   op_b = MUL_W'(falloff);  end
            OP_DEN_B:  begin op_a = den_reg; op_b = MUL_W'(amplitude_recip);   end
            OP_NUM_A:  begin op_a = MUL_W'(sv_reg);   op_b = MUL_W'(falloff);  end
            OP_INN_A:  begin op_a = MUL_W'(sv_reg);   op_b = MUL_W'(falloff);  end
            OP_INN_P:  begin op_a = inn_reg; op_b = MUL_W'(falloff_pow_n1);    end
            OP_FIN:    begin op_a = MUL_W'(s0_reg);   op_b = acc2_reg;         end
            default:   begin op_a = '0;               op_b = '0;               end
        endcase
    end

    // Divider step and sign magnitudes
    assign un = num_reg[MUL_W-1] ? MUL_W'(-num_reg) : num_reg;
    assign ud = db_reg[40] ? 41'(-db_reg) : db_reg;
    assign sh = {rem_reg, lsb_reg};
    assign ge = sh >= {1'b0, ud_reg};

    // Saturated, signed result
    always_comb begin
        if (neg_reg) begin
            res = (sat_reg || quo_reg > MAG_NEG) ? MAG_NEG : SB'(-quo_reg);
        end else begin
            res = (sat_reg || quo_reg > MAG_MAX) ? MAG_MAX : quo_reg;
        end
    end

    // Phase accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_reg <= '0;
            be_reg <= '0;
        end else if (cmd.load) begin
            th_reg <= th_reg + carrier_step[STEP_W-1 -: PB];
            be_reg <= be_reg + modulator_step[STEP_W-1 -: PB];
        end
    end

    // Shared multiplier with registered product
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            prod_reg <= op_a * op_b;
        end
    end

    // Write back of each step
    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            case (cmd.op)
                OP_NB:      nb_reg   <= prod_reg[PB-1:0];
                OP_ANG_CB:  ang_reg  <= be_reg + QTR;
                OP_SIN_T2:  t2_reg   <= prod_reg[56:28];
                OP_SIN_A5:  pacc_reg <= SIN_C5 - prod_reg[56:28];
                OP_SIN_A3:  pacc_reg <= SIN_C3 - prod_reg[56:28];
                OP_SIN_A1:  pacc_reg <= SIN_C1 - prod_reg[56:28];
                OP_SIN_S: begin
                    sv_reg <= idx[LB-1] ? -signed'({1'b0, sv_mag}) : signed'({1'b0, sv_mag});
                end
                OP_DEN_A:   den_reg  <= Q28_ONE + a2q - (p16 <<< 1);
                OP_DEN_B:   db_reg   <= p_sh16[40:0];
                OP_ANG_T:   ang_reg  <= th_reg;
                OP_SAVE_S0: begin
                    s0_reg   <= sv_reg;
                    ang_reg  <= th_reg - be_reg;
                    acc2_reg <= Q28_ONE - a2q;
                end
                OP_NUM_A:   acc2_reg <= MUL_W'(s0_reg) - p16;
                OP_ANG_K1:  ang_reg  <= base + nb_reg + be_reg;
                OP_ANG_K0: begin
                    inn_reg <= MUL_W'(sv_reg);
                    ang_reg <= base + nb_reg;
                end
                OP_INN_A:   inn_reg  <= inn_reg - p16;
                OP_INN_P: begin
                    acc2_reg <= acc2_reg - ((mode == MODE_UP_BL) ? p16 : (p16 <<< 1));
                end
                OP_FIN: begin
                    num_reg <= ((mode == MODE_UD_BL) || (mode == MODE_UD_UL)) ?
                               signed'(p_sh28[MUL_W-1:0]) : acc2_reg;
                end
                default: ;
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= 41'(un >> 1);
            lsb_reg <= un[0];
            ud_reg  <= ud;
            quo_reg <= '0;
            blk_reg <= (db_reg == '0);
            sat_reg <= 42'(un) >= {ud, 1'b0};
            neg_reg <= num_reg[MUL_W-1] != db_reg[40];
        end else if (cmd.div_step) begin
            rem_reg <= ge ? 41'(sh - {1'b0, ud_reg}) : sh[40:0];
            lsb_reg <= 1'b0;
            quo_reg <= {quo_reg[SB-2:0], ge};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sample_reg  <= blk_reg ? '0 : res;
            blocked_reg <= blk_reg;
        end
    end

    assign stat.out_full = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign sample        = sample_reg;
    assign blocked       = blocked_reg;

endmodule

>>> src/dsf_oscillator_top.sv
// Mode 3 takes the shortest time per transaction and mode 0 the longest (up
// to five sines on one shared multiplier, each multiply step issued and
// written back in turn, followed by the serial divider and output load).
// One transaction at a time: the next is accepted once the result is
// loaded into the output register. Reset: synchronous, active low; clears
// phases, sequencer and output valid, and loads register defaults.
// Top level of the DSF oscillator; depends on dsfo_pkg, dsfo_ctrl,
// dsfo_datapath. Holds the configuration registers.
module dsf_oscillator_top
    import dsfo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    localparam int M_DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*STEP_W-1:0]   s_tdata,  // carrier_step, modulator_step
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // sample
    output logic [0:0]            m_tuser,  // blocked
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]             mode_reg;
    logic [9:0]             bands_reg;
    logic [15:0]            fall_reg, fall2_reg, fallp_reg;
    logic [23:0]            amp_reg;
    dsfo_cmd_t              cmd;
    dsfo_stat_t             stat;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   blocked;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_UD_UL;
            bands_reg <= 10'd8;
            fall_reg  <= 16'd32768;
            fall2_reg <= 16'd16384;
            fallp_reg <= 16'd0;
            amp_reg   <= 24'd65536;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_BANDS: bands_reg <= cfg_data[9:0];
                REG_FALL:  fall_reg  <= cfg_data[15:0];
                REG_FALL2: fall2_reg <= cfg_data[15:0];
                REG_FALLP: fallp_reg <= cfg_data[15:0];
                REG_AMP:   amp_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    dsfo_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (mode_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsfo_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (mode_reg),
        .band_count      (bands_reg),
        .falloff         (fall_reg),
        .falloff_squared (fall2_reg),
        .falloff_pow_n1  (fallp_reg),
        .amplitude_recip (amp_reg),
        .carrier_step    (s_tdata[STEP_W-1:0]),
        .modulator_step  (s_tdata[2*STEP_W-1:STEP_W]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .sample          (sample),
        .blocked         (blocked)
    );

    assign m_tdata    = M_DATA_W'(sample);
    assign m_tuser[0] = blocked;

endmodule

>>> tb/dsfo_checker.sv
// Checker for the DSF oscillator: watches both stream channels, predicts each
// sample from the accepted phase steps and compares it. Depends on dsfo_pkg.
module dsfo_checker
    import dsfo_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [2*STEP_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] sample;
        logic        blocked;
    } osc_out_t;

    osc_out_t      sample_q[$];
    logic [1:0]    sel_mode;
    logic [9:0]    bands;
    logic [15:0]   fall_a, fall_a2, fall_p;
    logic [23:0]   amp_b;
    logic [31:0]   car_ph, mod_ph;

    localparam longint ONE_Q28 = 64'sd1 << 28;

    // Floor division by 2^n; >>> on signed longint floors already
    function automatic longint fl_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint mulf(longint x, logic [15:0] r);
        return fl_shr(x * longint'({16'd0, r}), 16);
    endfunction

    // Quarter-resolution table sine of a Q0.32 angle, result Q.28
    function automatic longint tsin(logic [31:0] x);
        longint unsigned idx, u, q, t, t2, acc;
        idx = (longint'(x) * 1024) >> 32;
        u = idx * 4;
        q = u / 1024;
        t = ((u % 1024) << 28) / 1024;
        if (q[0]) t = (64'd1 << 28) - t;
        t2 = (t * t) >> 28;
        acc = 21392326 - ((t2 * 1256749) >> 28);
        acc = 173399667 - ((t2 * acc) >> 28);
        acc = 421657428 - ((t2 * acc) >> 28);
        acc = (t * acc) >> 28;
        return q[1] ? -longint'(acc) : longint'(acc);
    endfunction

    function automatic longint tcos(logic [31:0] x);
        return tsin(x + 32'h4000_0000);
    endfunction

    // Advance phases and form one oscillator sample
    function automatic osc_out_t next_sample(logic [31:0] cstep, logic [31:0] mstep);
        osc_out_t r;
        logic [31:0] th, be;
        longint s0, num, fac, den, db, inner, mag;
        longint unsigned un, ud;
        bit neg;
        car_ph = car_ph + cstep;
        mod_ph = mod_ph + mstep;
        th = car_ph;
        be = mod_ph;
        s0 = tsin(th);
        if (sel_mode == MODE_UP_BL || sel_mode == MODE_UP_UL) begin
            num = s0 - mulf(tsin(th - be), fall_a);
            if (sel_mode == MODE_UP_BL) begin
                inner = tsin(th + (bands + 32'd1) * be) - mulf(tsin(th + bands * be), fall_a);
                num -= mulf(inner, fall_p);
            end
        end else begin
            fac = ONE_Q28 - (longint'(fall_a2) << 12);
            if (sel_mode == MODE_UD_BL) begin
                inner = tcos((bands + 32'd1) * be) - mulf(tcos(bands * be), fall_a);
                fac -= 2 * mulf(inner, fall_p);
            end
            num = fl_shr(s0 * fac, 28);
        end
        den = ONE_Q28 + (longint'(fall_a2) << 12) - 2 * mulf(tcos(be), fall_a);
        db = fl_shr(den * longint'(amp_b), 16);
        if (db == 0) begin
            r.sample = '0;
            r.blocked = 1'b1;
            return r;
        end
        neg = (num < 0) != (db < 0);
        un = num < 0 ? -num : num;
        ud = db < 0 ? -db : db;
        mag = longint'((un << 23) / ud);
        if (neg) begin
            if (mag > 64'd8388608) mag = 8388608;
            mag = -mag;
        end else if (mag > 64'd8388607) begin
            mag = 8388607;
        end
        r.sample = mag[23:0];
        r.blocked = 1'b0;
        return r;
    endfunction

    assign pending = sample_q.size();

    always @(posedge aclk) begin
        osc_out_t exp_r;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            sel_mode <= MODE_UD_UL;
            bands    <= 10'd8;
            fall_a   <= 16'd32768;
            fall_a2  <= 16'd16384;
            fall_p   <= 16'd0;
            amp_b    <= 24'd65536;
            car_ph   = '0;
            mod_ph   = '0;
            sample_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MODE:  sel_mode <= cfg_data[1:0];
                    REG_BANDS: bands    <= cfg_data[9:0];
                    REG_FALL:  fall_a   <= cfg_data[15:0];
                    REG_FALL2: fall_a2  <= cfg_data[15:0];
                    REG_FALLP: fall_p   <= cfg_data[15:0];
                    REG_AMP:   amp_b    <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                sample_q.push_back(next_sample(s_tdata[31:0], s_tdata[63:32]));
            // Compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected result transaction sample=%0d", $signed(m_tdata));
                    errs++;
                end else begin
                    exp_r = sample_q.pop_front();
                    if (m_tdata !== exp_r.sample) begin
                        $error("sample: expected %0d got %0d",
                               $signed(exp_r.sample), $signed(m_tdata));
                        errs++;
                    end
                    if (m_tuser[0] !== exp_r.blocked) begin
                        $error("blocked: expected %0b got %0b", exp_r.blocked, m_tuser[0]);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

>>> tb/tb_top.sv
// Testbench top for dsf_oscillator_top: clock, reset, configuration phases
// and phase-step stimulus; depends on dsfo_pkg and dsfo_checker.
module tb_top;
    import dsfo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 20000;

    logic                  aclk, aresetn;
    logic                  s_tvalid, s_tready, m_tvalid, m_tready;
    logic [2*STEP_W-1:0]   s_tdata;
    logic [23:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count, pending;
    int                    src_idle, snk_idle, quiet_cycles;

    dsf_oscillator_top u_dut (.*);

    dsfo_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stalls at random
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= snk_idle);
    end

    // Watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_we   <= 1'b0;
    endtask

    // One step transaction, with random sender idle cycles before it
    task automatic send_step(logic [31:0] cstep, logic [31:0] mstep);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mstep, cstep};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_step();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h0;
            2: return $urandom_range(32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    // Stop sending and wait until every prediction has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [15:0] a;
        a = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
        write_reg(REG_MODE, $urandom_range(3));
        write_reg(REG_BANDS, $urandom_range(2) == 0 ? 1023 : $urandom_range(0, 40));
        write_reg(REG_FALL, 32'(a));
        write_reg(REG_FALL2, $urandom_range(4) == 0 ? $urandom_range('hFFFF) :
                             (32'(a) * 32'(a)) >> 16);
        write_reg(REG_FALLP, $urandom_range('hFFFF));
        case ($urandom_range(4))
            0: write_reg(REG_AMP, 1);
            1: write_reg(REG_AMP, 'hFFFFFF);
            default: write_reg(REG_AMP, $urandom_range('h2000, 'h40000));
        endcase
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        src_idle = 11;
        snk_idle = 45;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: defaults, step extremes, every mode, small divisor, N = 0
        send_step(32'h0, 32'h0);
        send_step(32'h8000_0000, 32'h8000_0000);
        send_step(32'hFFFF_FFFF, 32'h0000_0001);
        for (int m = 0; m < 4; m++) begin
            drain();
            write_reg(REG_MODE, m);
            write_reg(REG_BANDS, m == 0 ? 0 : 1023);
            write_reg(REG_FALL, 'hFFFF);
            write_reg(REG_FALL2, 'hFFFE);
            write_reg(REG_FALLP, m[0] ? 0 : 'hFFFF);
            write_reg(REG_AMP, 'hFFFFFF);
            send_step(32'h1000_0000, 32'h0400_0000);
            send_step(32'h5555_5555, 32'hAAAA_AAAA);
            // Small divisor with a = 0.5, a2 = 0.25 and amplitude reciprocal 1
            drain();
            write_reg(REG_FALL, 'h8000);
            write_reg(REG_FALL2, 'h4000);
            write_reg(REG_AMP, 1);
            send_step(32'h0123_4567, 32'h0);
            send_step(32'h7654_3210, 32'h8000_0000);
        end

        // Random phases with varying configuration
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin src_idle = 45; snk_idle = 11; end
            if (ph == 2) begin src_idle = 0;  snk_idle = 0;  end
            for (int blk = 0; blk < 6; blk++) begin
                drain();
                random_config();
                repeat (36) send_step(rand_step(), rand_step());
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

>>> filelist.f
src/dsfo_pkg.sv
src/dsfo_ctrl.sv
src/dsfo_datapath.sv
src/dsf_oscillator_top.sv
tb/dsfo_checker.sv
tb/tb_top.sv
